// ===== hw/rtl/acp_pkg.sv =====
// ----------------------------------------------------------------------------
// acp_pkg
// shared types, opcodes and control word layout of the accumulator core
// ----------------------------------------------------------------------------
`default_nettype none

package acp_pkg;

  // data path and memory geometry
  localparam int DATA_W    = 8;
  localparam int ADDR_W    = 8;
  localparam int MEM_DEPTH = 256;
  localparam int CNT_OUT_W = 32;

  // request codes carried by the input item
  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_EXEC    = 2'd2,
    REQ_RESTART = 2'd3
  } req_t;

  // instruction opcodes
  localparam logic [7:0] OP_NOP = 8'h00;
  localparam logic [7:0] OP_LDR = 8'h10;
  localparam logic [7:0] OP_STR = 8'h20;
  localparam logic [7:0] OP_ADD = 8'h30;
  localparam logic [7:0] OP_SUB = 8'h40;
  localparam logic [7:0] OP_MUL = 8'h50;
  localparam logic [7:0] OP_DIV = 8'h60;
  localparam logic [7:0] OP_NOT = 8'h70;
  localparam logic [7:0] OP_AND = 8'h80;
  localparam logic [7:0] OP_OR  = 8'h90;
  localparam logic [7:0] OP_XOR = 8'hA0;
  localparam logic [7:0] OP_JMP = 8'hB0;
  localparam logic [7:0] OP_JEQ = 8'hC0;
  localparam logic [7:0] OP_JG  = 8'hD0;
  localparam logic [7:0] OP_JL  = 8'hE0;
  localparam logic [7:0] OP_HLT = 8'hF0;

  // microprogram step addresses
  typedef enum logic [3:0] {
    U_IDLE     = 4'd0,
    U_WR       = 4'd1,
    U_RD       = 4'd2,
    U_RD_CAP   = 4'd3,
    U_FETCH    = 4'd4,
    U_OPND     = 4'd5,
    U_ADDR     = 4'd6,
    U_MREAD    = 4'd7,
    U_MCAP     = 4'd8,
    U_DIV_GO   = 4'd9,
    U_DIV_WAIT = 4'd10,
    U_COMMIT   = 4'd11,
    U_RESTART  = 4'd12,
    U_EMIT     = 4'd13
  } upc_t;

  // memory address source
  typedef enum logic [1:0] {
    AS_REQ  = 2'd0,
    AS_PC   = 2'd1,
    AS_PC1  = 2'd2,
    AS_OPND = 2'd3
  } addr_sel_t;

  // sequencing mode of a step
  typedef enum logic [2:0] {
    SQ_NEXT     = 3'd0,
    SQ_GOTO     = 3'd1,
    SQ_BRANCH   = 3'd2,
    SQ_WAIT     = 3'd3,
    SQ_DISPATCH = 3'd4
  } seq_t;

  // branch and wait conditions
  typedef enum logic [1:0] {
    CC_HALTED   = 2'd0,
    CC_NOT_DIV  = 2'd1,
    CC_DIV_DONE = 2'd2,
    CC_OUT_FREE = 2'd3
  } cond_t;

  // one control word of the microprogram
  typedef struct packed {
    logic      in_rdy;
    addr_sel_t addr_sel;
    logic      mem_rd;
    logic      mem_wr;
    logic      str_wr;
    logic      wd_acc;
    logic      ld_rdata;
    logic      ld_op;
    logic      ld_opnd;
    logic      ld_m;
    logic      div_go;
    logic      act_exec;
    logic      act_restart;
    logic      ld_out;
    seq_t      seq;
    cond_t     cond;
    upc_t      tgt;
  } ctl_t;

  // status fed back from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    req_t in_req;
    logic halted;
    logic not_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/acp_in_if.sv =====
// ----------------------------------------------------------------------------
// acp_in_if
// request channel: valid/ready handshake with one request item
// ----------------------------------------------------------------------------
`default_nettype none

interface acp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] address;
  logic [7:0] write_data;

  modport source (output valid, output req_type, output address, output write_data,
                  input ready);
  modport sink   (input valid, input req_type, input address, input write_data,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/acp_out_if.sv =====
// ----------------------------------------------------------------------------
// acp_out_if
// result channel: valid/ready handshake with one processor state item
// ----------------------------------------------------------------------------
`default_nettype none

interface acp_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        read_data;
  logic signed [7:0] accumulator;
  logic [7:0]        program_counter;
  logic              halted;
  logic              illegal;
  logic [31:0]       executed_count;

  modport source (output valid, output read_data, output accumulator,
                  output program_counter, output halted, output illegal,
                  output executed_count, input ready);
  modport sink   (input valid, input read_data, input accumulator,
                  input program_counter, input halted, input illegal,
                  input executed_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/acp_ram.sv =====
// ----------------------------------------------------------------------------
// acp_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module acp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/acp_div.sv =====
// ----------------------------------------------------------------------------
// acp_div
// signed 8-bit divider, restoring, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module acp_div (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       go,
  input  wire logic [7:0] dividend,
  input  wire logic [7:0] divisor,
  output logic            busy,
  output logic [7:0]      quot
);

  localparam int STEPS  = 8;
  localparam int STEP_W = $clog2(STEPS + 1);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [7:0]        num_r;
  logic [7:0]        den_r;
  logic [7:0]        rem_r;
  logic              neg_r;
  logic [8:0]        rem_sh;
  logic              ge;
  logic [8:0]        rem_sub;

  // one restoring step on the shifted remainder
  always_comb begin
    rem_sh  = {rem_r, num_r[7]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(STEPS);
    end else if (busy_r) begin
      busy_r <= step_r != STEP_W'(1);
      step_r <= step_r - STEP_W'(1);
    end
  end

  // operand magnitudes, remainder and quotient shift
  always_ff @(posedge clk) begin
    if (go) begin
      num_r <= dividend[7] ? (8'd0 - dividend) : dividend;
      den_r <= divisor[7] ? (8'd0 - divisor) : divisor;
      rem_r <= '0;
      neg_r <= dividend[7] ^ divisor[7];
    end else if (busy_r) begin
      num_r <= {num_r[6:0], ge};
      rem_r <= ge ? rem_sub[7:0] : rem_sh[7:0];
    end
  end

  assign busy = busy_r;
  assign quot = neg_r ? (8'd0 - num_r) : num_r;

endmodule

`default_nettype wire

// ===== hw/rtl/acp_useq.sv =====
// ----------------------------------------------------------------------------
// acp_useq
// microcode sequencer: step counter, control store and branch logic
// ----------------------------------------------------------------------------
`default_nettype none

module acp_useq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire acp_pkg::sts_t sts,
  output acp_pkg::ctl_t      ctl,
  output acp_pkg::upc_t      upc
);

  acp_pkg::upc_t upc_r;
  acp_pkg::upc_t upc_nxt;
  acp_pkg::upc_t upc_inc;
  logic          take;

  // control store
  function automatic acp_pkg::ctl_t ucode(acp_pkg::upc_t step);
    acp_pkg::ctl_t c;
    c          = '0;
    c.addr_sel = acp_pkg::AS_REQ;
    c.seq      = acp_pkg::SQ_NEXT;
    c.cond     = acp_pkg::CC_HALTED;
    c.tgt      = acp_pkg::U_IDLE;
    unique case (step)
      acp_pkg::U_IDLE: begin
        c.in_rdy = 1'b1;
        c.seq    = acp_pkg::SQ_DISPATCH;
      end
      acp_pkg::U_WR: begin
        c.mem_wr = 1'b1;
        c.seq    = acp_pkg::SQ_GOTO;
        c.tgt    = acp_pkg::U_EMIT;
      end
      acp_pkg::U_RD: begin
        c.mem_rd = 1'b1;
      end
      acp_pkg::U_RD_CAP: begin
        c.ld_rdata = 1'b1;
        c.seq      = acp_pkg::SQ_GOTO;
        c.tgt      = acp_pkg::U_EMIT;
      end
      acp_pkg::U_FETCH: begin
        c.mem_rd   = 1'b1;
        c.addr_sel = acp_pkg::AS_PC;
        c.seq      = acp_pkg::SQ_BRANCH;
        c.cond     = acp_pkg::CC_HALTED;
        c.tgt      = acp_pkg::U_EMIT;
      end
      acp_pkg::U_OPND: begin
        c.ld_op    = 1'b1;
        c.mem_rd   = 1'b1;
        c.addr_sel = acp_pkg::AS_PC1;
      end
      acp_pkg::U_ADDR: begin
        c.ld_opnd = 1'b1;
      end
      acp_pkg::U_MREAD: begin
        c.mem_rd   = 1'b1;
        c.addr_sel = acp_pkg::AS_OPND;
      end
      acp_pkg::U_MCAP: begin
        c.ld_m = 1'b1;
      end
      acp_pkg::U_DIV_GO: begin
        c.div_go = 1'b1;
        c.seq    = acp_pkg::SQ_BRANCH;
        c.cond   = acp_pkg::CC_NOT_DIV;
        c.tgt    = acp_pkg::U_COMMIT;
      end
      acp_pkg::U_DIV_WAIT: begin
        c.seq  = acp_pkg::SQ_WAIT;
        c.cond = acp_pkg::CC_DIV_DONE;
        c.tgt  = acp_pkg::U_COMMIT;
      end
      acp_pkg::U_COMMIT: begin
        c.act_exec = 1'b1;
        c.str_wr   = 1'b1;
        c.wd_acc   = 1'b1;
        c.addr_sel = acp_pkg::AS_OPND;
        c.seq      = acp_pkg::SQ_GOTO;
        c.tgt      = acp_pkg::U_EMIT;
      end
      acp_pkg::U_RESTART: begin
        c.act_restart = 1'b1;
      end
      acp_pkg::U_EMIT: begin
        c.ld_out = 1'b1;
        c.seq    = acp_pkg::SQ_WAIT;
        c.cond   = acp_pkg::CC_OUT_FREE;
        c.tgt    = acp_pkg::U_IDLE;
      end
      default: begin
        c.seq = acp_pkg::SQ_GOTO;
      end
    endcase
    return c;
  endfunction

  // control word of the current step
  always_comb begin
    ctl = ucode(upc_r);
  end

  // condition select
  always_comb begin
    unique case (ctl.cond)
      acp_pkg::CC_HALTED:   take = sts.halted;
      acp_pkg::CC_NOT_DIV:  take = sts.not_div;
      acp_pkg::CC_DIV_DONE: take = sts.div_done;
      acp_pkg::CC_OUT_FREE: take = sts.out_free;
    endcase
  end

  // next step
  always_comb begin
    upc_inc = acp_pkg::upc_t'(upc_r + 4'd1);
    upc_nxt = upc_r;
    unique case (ctl.seq)
      acp_pkg::SQ_NEXT:   upc_nxt = upc_inc;
      acp_pkg::SQ_GOTO:   upc_nxt = ctl.tgt;
      acp_pkg::SQ_BRANCH: upc_nxt = take ? ctl.tgt : upc_inc;
      acp_pkg::SQ_WAIT: begin
        if (take) begin
          upc_nxt = ctl.tgt;
        end
      end
      acp_pkg::SQ_DISPATCH: begin
        if (sts.in_valid) begin
          unique case (sts.in_req)
            acp_pkg::REQ_WRITE:   upc_nxt = acp_pkg::U_WR;
            acp_pkg::REQ_READ:    upc_nxt = acp_pkg::U_RD;
            acp_pkg::REQ_EXEC:    upc_nxt = acp_pkg::U_FETCH;
            acp_pkg::REQ_RESTART: upc_nxt = acp_pkg::U_RESTART;
          endcase
        end
      end
      default: upc_nxt = acp_pkg::U_IDLE;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= acp_pkg::U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign upc = upc_r;

endmodule

`default_nettype wire

// ===== hw/rtl/accumulator_cpu_core.sv =====
// ----------------------------------------------------------------------------
// accumulator_cpu_core
// eight-bit accumulator processor with a 256-byte memory, microcoded control
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  in_ch     sink       valid / ready    req_type, address, write_data
//  out_ch    source     valid / ready    read_data, accumulator, program_counter,
//                                        halted, illegal, executed_count
//
//  a divide runs the microprogram steps plus eight divider iterations
//  the single memory port sets the fetch sequence: opcode, operand, data byte
//  reset clears the memory valid bits at once, so no clearing pass is needed
//  a finished result waits in the output register while the next item runs;
//  only the next result waits for the output register to drain
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_cpu_core #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  acp_in_if.sink     in_ch,
  acp_out_if.source  out_ch
);

  acp_pkg::ctl_t ctl;
  acp_pkg::sts_t sts;
  acp_pkg::upc_t upc;

  logic                        in_acc;
  logic [acp_pkg::ADDR_W-1:0]  req_addr_r;
  logic [acp_pkg::DATA_W-1:0]  req_wdata_r;

  logic [acp_pkg::DATA_W-1:0]  acc_r;
  logic [acp_pkg::ADDR_W-1:0]  pc_r;
  logic                        halt_r;
  logic                        ill_r;
  logic [COUNT_BITS-1:0]       cnt_r;
  logic [acp_pkg::DATA_W-1:0]  op_r;
  logic [acp_pkg::ADDR_W-1:0]  opnd_r;
  logic [acp_pkg::DATA_W-1:0]  m_r;
  logic [acp_pkg::DATA_W-1:0]  rdata_r;

  logic [acp_pkg::ADDR_W-1:0]  ram_addr;
  logic [acp_pkg::DATA_W-1:0]  ram_wdata;
  logic [acp_pkg::DATA_W-1:0]  ram_q;
  logic                        ram_we;
  logic [acp_pkg::MEM_DEPTH-1:0] vld_r;
  logic                        vld_q_r;
  logic [acp_pkg::DATA_W-1:0]  mem_q;

  logic                        div_busy;
  logic [acp_pkg::DATA_W-1:0]  div_q;

  logic [acp_pkg::DATA_W-1:0]  acc_nxt;
  logic [acp_pkg::ADDR_W-1:0]  pc_nxt;
  logic                        halt_nxt;
  logic                        ill_nxt;
  logic                        cnt_en;
  logic [15:0]                 prod;
  logic [acp_pkg::ADDR_W-1:0]  pc_p1;
  logic [acp_pkg::ADDR_W-1:0]  pc_p2;

  logic                          out_load;
  logic                          out_valid_r;
  logic [acp_pkg::DATA_W-1:0]    out_rdata_r;
  logic [acp_pkg::DATA_W-1:0]    out_acc_r;
  logic [acp_pkg::ADDR_W-1:0]    out_pc_r;
  logic                          out_halt_r;
  logic                          out_ill_r;
  logic [acp_pkg::CNT_OUT_W-1:0] out_cnt_r;
  logic [acp_pkg::CNT_OUT_W-1:0] cnt_view;

  // sequencer
  acp_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl),
    .upc   (upc)
  );

  assign in_acc   = in_ch.valid & ctl.in_rdy;
  assign in_ch.ready = ctl.in_rdy;
  assign out_load = ctl.ld_out & sts.out_free;

  // status back to the sequencer
  always_comb begin
    sts.in_valid = in_ch.valid;
    sts.in_req   = acp_pkg::req_t'(in_ch.req_type);
    sts.halted   = halt_r;
    sts.not_div  = op_r != acp_pkg::OP_DIV;
    sts.div_done = !div_busy;
    sts.out_free = !out_valid_r | out_ch.ready;
  end

  // latch the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_addr_r  <= in_ch.address;
      req_wdata_r <= in_ch.write_data;
    end
  end

  // memory address and write data
  always_comb begin
    unique case (ctl.addr_sel)
      acp_pkg::AS_REQ:  ram_addr = req_addr_r;
      acp_pkg::AS_PC:   ram_addr = pc_r;
      acp_pkg::AS_PC1:  ram_addr = pc_r + 8'd1;
      acp_pkg::AS_OPND: ram_addr = opnd_r;
    endcase
    ram_wdata = ctl.wd_acc ? acc_r : req_wdata_r;
    ram_we    = ctl.mem_wr | (ctl.str_wr & (op_r == acp_pkg::OP_STR));
  end

  acp_ram #(
    .WIDTH (acp_pkg::DATA_W),
    .DEPTH (acp_pkg::MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ctl.mem_rd),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  // written-entry flags, an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[ram_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_rd) begin
      vld_q_r <= vld_r[ram_addr];
    end
  end

  assign mem_q = vld_q_r ? ram_q : '0;

  // instruction operand registers and read result
  always_ff @(posedge clk) begin
    if (ctl.ld_op) begin
      op_r <= mem_q;
    end
    if (ctl.ld_opnd) begin
      opnd_r <= mem_q;
    end
    if (ctl.ld_m) begin
      m_r <= mem_q;
    end
    if (in_acc) begin
      rdata_r <= '0;
    end else if (ctl.ld_rdata) begin
      rdata_r <= mem_q;
    end
  end

  // divider, started only for a divide instruction
  acp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (ctl.div_go & !sts.not_div),
    .dividend (acc_r),
    .divisor  (m_r),
    .busy     (div_busy),
    .quot     (div_q)
  );

  // instruction execute
  always_comb begin
    pc_p1    = pc_r + 8'd1;
    pc_p2    = pc_r + 8'd2;
    prod     = {8'd0, acc_r} * {8'd0, m_r};
    acc_nxt  = acc_r;
    pc_nxt   = pc_r;
    halt_nxt = halt_r;
    ill_nxt  = ill_r;
    cnt_en   = 1'b1;
    unique case (op_r)
      acp_pkg::OP_NOP: pc_nxt = pc_p1;
      acp_pkg::OP_LDR: begin
        acc_nxt = m_r;
        pc_nxt  = pc_p2;
      end
      acp_pkg::OP_STR: pc_nxt = pc_p2;
      acp_pkg::OP_ADD: begin
        acc_nxt = acc_r + m_r;
        pc_nxt  = pc_p2;
      end
      acp_pkg::OP_SUB: begin
        acc_nxt = acc_r - m_r;
        pc_nxt  = pc_p2;
      end
      acp_pkg::OP_MUL: begin
        acc_nxt = prod[7:0];
        pc_nxt  = pc_p2;
      end
      acp_pkg::OP_DIV: begin
        // divide by zero keeps the accumulator
        if (m_r != 8'd0) begin
          acc_nxt = div_q;
        end
        pc_nxt = pc_p2;
      end
      acp_pkg::OP_NOT: begin
        acc_nxt = ~acc_r;
        pc_nxt  = pc_p1;
      end
      acp_pkg::OP_AND: begin
        acc_nxt = acc_r & m_r;
        pc_nxt  = pc_p2;
      end
      acp_pkg::OP_OR: begin
        acc_nxt = acc_r | m_r;
        pc_nxt  = pc_p2;
      end
      acp_pkg::OP_XOR: begin
        acc_nxt = acc_r ^ m_r;
        pc_nxt  = pc_p2;
      end
      acp_pkg::OP_JMP: pc_nxt = opnd_r;
      acp_pkg::OP_JEQ: pc_nxt = (acc_r == 8'd0) ? opnd_r : pc_p2;
      acp_pkg::OP_JG:  pc_nxt = (!acc_r[7] && acc_r != 8'd0) ? opnd_r : pc_p2;
      acp_pkg::OP_JL:  pc_nxt = acc_r[7] ? opnd_r : pc_p2;
      acp_pkg::OP_HLT: begin
        pc_nxt   = pc_p1;
        halt_nxt = 1'b1;
      end
      default: begin
        // unknown opcode: halt in place, count unchanged
        halt_nxt = 1'b1;
        ill_nxt  = 1'b1;
        cnt_en   = 1'b0;
      end
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.act_restart) begin
      acc_r  <= '0;
      pc_r   <= '0;
      halt_r <= 1'b0;
      ill_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.act_exec) begin
      acc_r  <= acc_nxt;
      pc_r   <= pc_nxt;
      halt_r <= halt_nxt;
      ill_r  <= ill_nxt;
      if (cnt_en && cnt_r != '1) begin
        cnt_r <= cnt_r + {{(COUNT_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

  // count as shown on the result channel
  generate
    if (COUNT_BITS >= acp_pkg::CNT_OUT_W) begin : g_cnt_trunc
      assign cnt_view = cnt_r[acp_pkg::CNT_OUT_W-1:0];
    end else begin : g_cnt_ext
      assign cnt_view = {{(acp_pkg::CNT_OUT_W-COUNT_BITS){1'b0}}, cnt_r};
    end
  endgenerate

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rdata_r <= rdata_r;
      out_acc_r   <= acc_r;
      out_pc_r    <= pc_r;
      out_halt_r  <= halt_r;
      out_ill_r   <= ill_r;
      out_cnt_r   <= cnt_view;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = out_rdata_r;
  assign out_ch.accumulator     = $signed(out_acc_r);
  assign out_ch.program_counter = out_pc_r;
  assign out_ch.halted          = out_halt_r;
  assign out_ch.illegal         = out_ill_r;
  assign out_ch.executed_count  = out_cnt_r;

  // checks
  a_ill_implies_halt: assert property (@(posedge clk) disable iff (!rst_n)
    ill_r |-> halt_r)
    else $error("illegal flag set without halt");

  a_no_exec_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.act_exec |-> !halt_r)
    else $error("instruction committed while halted");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.act_restart |=> (acc_r == '0 && pc_r == '0 && cnt_r == '0 && !halt_r && !ill_r))
    else $error("restart left processor state behind");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.act_restart |=> cnt_r >= $past(cnt_r))
    else $error("instruction count went down without restart");

  a_divider_idle_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (upc == acp_pkg::U_COMMIT) |-> !div_busy)
    else $error("commit while divider still busy");

endmodule

`default_nettype wire
